// ===== src/rhsv_pkg.sv =====
package rhsv_pkg;

  // Pixel channels and results
  localparam int PIX_W = 8;

  // Divider layout: saturation quotient is 8 bits, hue quotient is at most 43 (6 bits)
  localparam int SAT_QUO_W  = 8;
  localparam int HUE_QUO_W  = 6;
  localparam int SAT_REM_W  = 16;
  localparam int HUE_REM_W  = 14;
  localparam int DIV_STAGES = SAT_QUO_W;

  localparam logic [SAT_REM_W-1:0] SAT_SCALE = 16'd255;
  localparam logic [HUE_REM_W-1:0] HUE_SCALE = 14'd43;

  localparam logic [PIX_W-1:0] HUE_BASE_RED   = 8'd0;
  localparam logic [PIX_W-1:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [PIX_W-1:0] HUE_BASE_BLUE  = 8'd171;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rhsv_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
  } rhsv_out_t;

  // One slot of the divider pipeline: both divisions run side by side
  typedef struct packed {
    logic [PIX_W-1:0]     bright;
    logic [PIX_W-1:0]     sdiv;
    logic [SAT_REM_W-1:0] srem;
    logic [SAT_QUO_W-1:0] squo;
    logic [PIX_W-1:0]     hdiv;
    logic [HUE_REM_W-1:0] hrem;
    logic [HUE_QUO_W-1:0] hquo;
    logic                 hneg;
    logic [PIX_W-1:0]     hbase;
    logic                 black;
    logic                 grey;
  } rhsv_div_t;

endpackage

// ===== src/rgb_to_hsv_converter_unit.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data   (red, green, blue)
// out_      output     out_valid / out_ready  out_data  (hue, saturation, brightness)
//
// One pixel per clock sustained while out_ready stays high; an output stall holds the flow.
// Depth is set by the two restoring dividers, one saturation quotient bit per stage (8 stages),
// behind max/min, spread and numerator stages and the output register.
// rst_n (synchronous) clears only the stage valid bits.
// Each stage holds while its successor is full and stalled; empty stages keep loading,
// so bubbles close up under an output stall and nothing is dropped or repeated.
module rgb_to_hsv_converter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhsv_pkg::rhsv_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rhsv_pkg::rhsv_out_t out_data
);
  import rhsv_pkg::*;

  // stage 0: max/min, 1: spread/diff, 2: numerators, 3..10: divide, 11: output
  localparam int NSTG    = DIV_STAGES + 4;
  localparam int DIV_LO  = 3;
  localparam int OUT_STG = NSTG - 1;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  // stage 0
  logic [PIX_W-1:0] a_mx_r, a_mn_r, a_base_r, a_px_r, a_py_r;
  logic [PIX_W-1:0] a_mx_nxt, a_mn_nxt, a_base_nxt, a_px_nxt, a_py_nxt;

  // stage 1
  logic [PIX_W-1:0] b_mx_r, b_spread_r, b_base_r, b_mag_r;
  logic             b_neg_r;

  rhsv_div_t dv_r   [DIV_STAGES+1];
  rhsv_div_t dv_nxt [DIV_STAGES];
  rhsv_div_t dv_init;

  rhsv_out_t out_data_r;
  rhsv_out_t out_nxt;

  // per-stage ready: a stage moves when it is empty or its successor moves
  always_comb begin
    adv[OUT_STG] = !vld_r[OUT_STG] || out_ready;
    for (int k = OUT_STG - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[OUT_STG];
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 0: max, min, sector (red first, then green) and the pair to subtract
  always_comb begin
    a_mx_nxt = in_data.red;
    a_mn_nxt = in_data.red;
    if (in_data.green > a_mx_nxt) a_mx_nxt = in_data.green;
    if (in_data.blue  > a_mx_nxt) a_mx_nxt = in_data.blue;
    if (in_data.green < a_mn_nxt) a_mn_nxt = in_data.green;
    if (in_data.blue  < a_mn_nxt) a_mn_nxt = in_data.blue;
    priority if (a_mx_nxt == in_data.red) begin
      a_base_nxt = HUE_BASE_RED;
      a_px_nxt   = in_data.green;
      a_py_nxt   = in_data.blue;
    end else if (a_mx_nxt == in_data.green) begin
      a_base_nxt = HUE_BASE_GREEN;
      a_px_nxt   = in_data.blue;
      a_py_nxt   = in_data.red;
    end else begin
      a_base_nxt = HUE_BASE_BLUE;
      a_px_nxt   = in_data.red;
      a_py_nxt   = in_data.green;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_mx_r   <= a_mx_nxt;
      a_mn_r   <= a_mn_nxt;
      a_base_r <= a_base_nxt;
      a_px_r   <= a_px_nxt;
      a_py_r   <= a_py_nxt;
    end
  end

  // stage 1: spread and sign/magnitude of the hue difference
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      b_mx_r     <= a_mx_r;
      b_spread_r <= a_mx_r - a_mn_r;
      b_base_r   <= a_base_r;
      b_neg_r    <= a_px_r < a_py_r;
      b_mag_r    <= (a_px_r < a_py_r) ? (a_py_r - a_px_r) : (a_px_r - a_py_r);
    end
  end

  // stage 2: numerators 255*spread and 43*|diff|
  always_comb begin
    dv_init.bright = b_mx_r;
    dv_init.sdiv   = b_mx_r;
    dv_init.srem   = SAT_REM_W'(b_spread_r) * SAT_SCALE;
    dv_init.squo   = '0;
    dv_init.hdiv   = b_spread_r;
    dv_init.hrem   = HUE_REM_W'(b_mag_r) * HUE_SCALE;
    dv_init.hquo   = '0;
    dv_init.hneg   = b_neg_r;
    dv_init.hbase  = b_base_r;
    dv_init.black  = (b_mx_r == '0);
    dv_init.grey   = (b_spread_r == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dv_r[0] <= dv_init;
    end
  end

  // restoring division, one saturation quotient bit per stage; hue takes bits in the last HUE_QUO_W stages
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int SH = DIV_STAGES - 1 - j;

    always_comb begin
      dv_nxt[j] = dv_r[j];
      if (dv_r[j].srem >= (SAT_REM_W'(dv_r[j].sdiv) << SH)) begin
        dv_nxt[j].srem = dv_r[j].srem - (SAT_REM_W'(dv_r[j].sdiv) << SH);
        dv_nxt[j].squo = {dv_r[j].squo[SAT_QUO_W-2:0], 1'b1};
      end else begin
        dv_nxt[j].squo = {dv_r[j].squo[SAT_QUO_W-2:0], 1'b0};
      end
      // hue quotient stays below 64, so only its low bits take steps
      if (SH < HUE_QUO_W) begin
        if (dv_r[j].hrem >= (HUE_REM_W'(dv_r[j].hdiv) << SH)) begin
          dv_nxt[j].hrem = dv_r[j].hrem - (HUE_REM_W'(dv_r[j].hdiv) << SH);
          dv_nxt[j].hquo = {dv_r[j].hquo[HUE_QUO_W-2:0], 1'b1};
        end else begin
          dv_nxt[j].hquo = {dv_r[j].hquo[HUE_QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[DIV_LO+j]) begin
        dv_r[j+1] <= dv_nxt[j];
      end
    end
  end

  // output: black and grey pixels bypass the (zero-divisor) quotients
  always_comb begin
    rhsv_div_t d;
    d = dv_r[DIV_STAGES];
    out_nxt.brightness = d.bright;
    out_nxt.saturation = d.black ? '0 : d.squo;
    if (d.grey) begin
      out_nxt.hue = '0;
    end else if (d.hneg) begin
      out_nxt.hue = d.hbase - PIX_W'(d.hquo);
    end else begin
      out_nxt.hue = d.hbase + PIX_W'(d.hquo);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STG]) begin
      out_data_r <= out_nxt;
    end
  end

endmodule
